### rtl/priority_task_scheduler_with_delays_defines.svh
`ifndef PRIORITY_TASK_SCHEDULER_WITH_DELAYS_DEFINES_SVH
`define PRIORITY_TASK_SCHEDULER_WITH_DELAYS_DEFINES_SVH

// same-cycle implication on clk_i, off during reset
`define PTS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// next-cycle implication on clk_i, off during reset
`define PTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

### rtl/pts_pkg.sv
`default_nettype none

package pts_pkg;

  localparam int TASK_SLOTS = 32;
  localparam int DELAY_BITS = 32;
  localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int PRIO_W     = 5;
  localparam int TICK_W     = 32;
  localparam int DTICK_W    = 32;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TASK_SLOTS - 1);

  // ready search looks at one byte of slots per cycle
  localparam int GROUPS = (TASK_SLOTS + 7) / 8;
  localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam logic [GRP_W-1:0] GRP_LAST = GRP_W'(GROUPS - 1);

  localparam int CMD_DEPTH = 2;
  localparam int CPTR_W    = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CCNT_W    = $clog2(CMD_DEPTH + 1);
  localparam logic [CPTR_W-1:0] CPTR_LAST = CPTR_W'(CMD_DEPTH - 1);

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_CREATE = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_DELAY  = 2'd3
  } pts_mode_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_TICK,
    OP_CREATE,
    OP_DELETE,
    OP_DELAY,
    OP_WAKE
  } pts_op_e;

  typedef struct packed {
    pts_mode_e          mode;
    logic [PRIO_W-1:0]  task_prio;
    logic [DTICK_W-1:0] delay_ticks;
  } pts_in_t;

  typedef struct packed {
    logic [PRIO_W-1:0] next_prio;
    logic              none_ready;
    logic [TICK_W-1:0] tick_now;
  } pts_out_t;

  typedef struct packed {
    pts_op_e               op;
    logic [SLOT_W-1:0]     slot;
    logic [DELAY_BITS-1:0] delay;
  } pts_cmd_t;

  typedef struct packed {
    logic busy;
    logic sweeping;
  } pts_stat_t;

endpackage

`default_nettype wire

### rtl/pts_front.sv
`default_nettype none

module pts_front import pts_pkg::*; (
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  pts_in_t  in_data_i,
  output logic     cmd_valid_o,
  input  logic     cmd_ready_i,
  output pts_cmd_t cmd_o
);

  logic                  in_range;
  logic [DELAY_BITS-1:0] delay_fit;

  assign in_range  = (32'(in_data_i.task_prio) < TASK_SLOTS);
  // delay taken modulo the counter width
  assign delay_fit = DELAY_BITS'(64'(in_data_i.delay_ticks));

  always_comb begin
    cmd_o.slot  = SLOT_W'(in_data_i.task_prio);
    cmd_o.delay = delay_fit;
    unique case (in_data_i.mode)
      MODE_TICK:   cmd_o.op = OP_TICK;
      MODE_CREATE: cmd_o.op = in_range ? OP_CREATE : OP_NONE;
      MODE_DELETE: cmd_o.op = in_range ? OP_DELETE : OP_NONE;
      MODE_DELAY: begin
        if (!in_range) begin
          cmd_o.op = OP_NONE;
        end else if (delay_fit == '0) begin
          cmd_o.op = OP_WAKE;
        end else begin
          cmd_o.op = OP_DELAY;
        end
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

  assign cmd_valid_o = in_valid_i;
  assign in_ready_o  = cmd_ready_i;

endmodule

`default_nettype wire

### rtl/pts_cmd_fifo.sv
`default_nettype none

module pts_cmd_fifo import pts_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  pts_cmd_t push_data_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output pts_cmd_t pop_data_o
);

  pts_cmd_t          entry_q [CMD_DEPTH];
  logic [CPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != CCNT_W'(CMD_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == CPTR_LAST) ? '0 : wr_ptr_q + CPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == CPTR_LAST) ? '0 : rd_ptr_q + CPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/pts_exec.sv
`default_nettype none

module pts_exec import pts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_ready_o,
  input  pts_cmd_t  cmd_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output pts_out_t  out_data_o,
  output pts_stat_t stat_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_TICK_END,
    S_FIND,
    S_EMIT
  } state_e;

  state_e                  state_q;
  logic [TASK_SLOTS-1:0]   present_q;
  logic [TASK_SLOTS-1:0]   delaying_q;
  logic [TICK_W-1:0]       tick_q;
  logic [SLOT_W-1:0]       addr_q;
  logic [SLOT_W-1:0]       rd_slot_q;
  logic                    rd_vld_q;
  logic [GRP_W-1:0]        grp_q;
  logic [PRIO_W-1:0]       res_prio_q;
  logic                    res_none_q;
  logic                    out_valid_q;
  pts_out_t                out_data_q;

  logic [DELAY_BITS-1:0]   delay_mem_q [TASK_SLOTS];
  logic [DELAY_BITS-1:0]   rd_data_q;

  logic                    wr_en;
  logic [SLOT_W-1:0]       wr_addr;
  logic [DELAY_BITS-1:0]   wr_data;
  logic [DELAY_BITS-1:0]   dec;
  logic                    wb_hit;
  logic [GROUPS*8-1:0]     ready_pad;
  logic [7:0]              chunk;
  logic [2:0]              chunk_pos;
  logic                    start_delay;

  function automatic logic [2:0] first_set(input logic [7:0] b);
    logic [2:0] r;
    r = '0;
    for (int i = 7; i >= 0; i--) begin
      if (b[i]) r = 3'(i);
    end
    return r;
  endfunction

  assign cmd_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign stat_o.busy     = (state_q != S_IDLE);
  assign stat_o.sweeping = (state_q == S_TICK) || (state_q == S_TICK_END);

  // counter writeback in the cycle after the sweep read
  assign dec    = rd_data_q - DELAY_BITS'(1);
  assign wb_hit = rd_vld_q && present_q[rd_slot_q] && delaying_q[rd_slot_q];

  assign start_delay = (state_q == S_IDLE) && cmd_valid_i && (cmd_i.op == OP_DELAY) &&
                       present_q[cmd_i.slot];

  always_comb begin
    if (wb_hit) begin
      wr_en   = 1'b1;
      wr_addr = rd_slot_q;
      wr_data = dec;
    end else begin
      wr_en   = start_delay;
      wr_addr = cmd_i.slot;
      wr_data = cmd_i.delay;
    end
  end

  assign ready_pad = (GROUPS*8)'(present_q & ~delaying_q);
  assign chunk     = ready_pad[8*grp_q +: 8];
  assign chunk_pos = first_set(chunk);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      delay_mem_q[wr_addr] <= wr_data;
    end
    if (state_q == S_TICK) begin
      rd_data_q <= delay_mem_q[addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      present_q   <= '0;
      delaying_q  <= '0;
      tick_q      <= '0;
      addr_q      <= '0;
      rd_slot_q   <= '0;
      rd_vld_q    <= 1'b0;
      grp_q       <= '0;
      res_prio_q  <= '0;
      res_none_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      rd_vld_q <= (state_q == S_TICK);
      if (state_q == S_TICK) begin
        rd_slot_q <= addr_q;
      end
      if (wb_hit && (dec == '0)) begin
        delaying_q[rd_slot_q] <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            grp_q   <= '0;
            state_q <= (cmd_i.op == OP_TICK) ? S_TICK : S_FIND;
            unique case (cmd_i.op)
              OP_TICK: begin
                tick_q <= tick_q + TICK_W'(1);
                addr_q <= '0;
              end
              OP_CREATE: begin
                present_q[cmd_i.slot]  <= 1'b1;
                delaying_q[cmd_i.slot] <= 1'b0;
              end
              OP_DELETE: begin
                present_q[cmd_i.slot]  <= 1'b0;
                delaying_q[cmd_i.slot] <= 1'b0;
              end
              OP_DELAY: begin
                if (present_q[cmd_i.slot]) begin
                  delaying_q[cmd_i.slot] <= 1'b1;
                end
              end
              // an absent slot is never delaying, so no present check
              OP_WAKE: delaying_q[cmd_i.slot] <= 1'b0;
              default: ;
            endcase
          end
        end
        S_TICK: begin
          if (addr_q == SLOT_LAST) begin
            state_q <= S_TICK_END;
          end else begin
            addr_q <= addr_q + SLOT_W'(1);
          end
        end
        S_TICK_END: state_q <= S_FIND;
        S_FIND: begin
          if (chunk != '0) begin
            res_prio_q <= PRIO_W'({grp_q, chunk_pos});
            res_none_q <= 1'b0;
            state_q    <= S_EMIT;
          end else if (grp_q == GRP_LAST) begin
            res_prio_q <= '0;
            res_none_q <= 1'b1;
            state_q    <= S_EMIT;
          end else begin
            grp_q <= grp_q + GRP_W'(1);
          end
        end
        S_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q           <= 1'b1;
            out_data_q.next_prio  <= res_prio_q;
            out_data_q.none_ready <= res_none_q;
            out_data_q.tick_now   <= tick_q;
            state_q               <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/priority_task_scheduler_with_delays.sv
// channel  | direction | handshake                | beat
// ---------+-----------+--------------------------+-------------------------------
// in       | input     | in_valid_i / in_ready_o  | in_data_i  (mode, prio, delay)
// out      | output    | out_valid_o / out_ready_i| out_data_o (next, none, tick)
//
// a tick runs a one-slot-per-cycle sweep in the back end through the single delay
// counter memory, then the ready search
// create, delete and delay run only the ready search, 8 slots a cycle
// a two-beat command queue takes input while the back end works or the result waits
// reset clears flags, tick counter and queue at once; no clearing pass for the counters
// a stalled result holds the back end in its last state; the queue fills behind it
`default_nettype none

`include "priority_task_scheduler_with_delays_defines.svh"

module priority_task_scheduler_with_delays import pts_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  pts_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output pts_out_t out_data_o
);

  logic      fr_valid, fr_ready;
  pts_cmd_t  fr_cmd;
  logic      cmd_valid, cmd_ready;
  pts_cmd_t  cmd;
  pts_stat_t stat;

  pts_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (fr_valid),
    .cmd_ready_i (fr_ready),
    .cmd_o       (fr_cmd)
  );

  pts_cmd_fifo u_cmd_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_cmd),
    .pop_valid_o  (cmd_valid),
    .pop_ready_i  (cmd_ready),
    .pop_data_o   (cmd)
  );

  pts_exec u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .stat_o      (stat)
  );

  `PTS_ASSERT_NEXT(a_tick_sweeps, cmd_valid && cmd_ready && (cmd.op == OP_TICK), stat.sweeping)
  `PTS_ASSERT_IMPL(a_none_zero, out_valid_o && out_data_o.none_ready, out_data_o.next_prio == '0)
  `PTS_ASSERT_IMPL(a_result_from_busy, $rose(out_valid_o), $past(stat.busy))

endmodule

`default_nettype wire

### tb/priority_task_scheduler_with_delays_tb.sv
`timescale 1ns / 100ps

module priority_task_scheduler_with_delays_tb;
  import pts_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int RAND_OPS   = 1200;
  localparam int DRAIN_WAIT = 60;

  typedef struct {
    pts_in_t  beat;
    bit       known;
    pts_out_t want;
  } sched_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready_o;
  pts_in_t  in_data = '0;
  logic     out_valid_o;
  logic     out_ready = 1'b0;
  pts_out_t out_data_o;

  // shadow of the scheduler table
  bit                    task_here [TASK_SLOTS] = '{default: 1'b0};
  bit                    task_waiting [TASK_SLOTS] = '{default: 1'b0};
  logic [DELAY_BITS-1:0] wait_left [TASK_SLOTS] = '{default: '0};
  logic [TICK_W-1:0]     tick_cnt = '0;

  pts_out_t   next_task_q[$];
  sched_row_t dir_rows[$];
  int         err_cnt = 0;
  int         idle_cycles = 0;
  int         send_gap_max = 11;
  int         take_stall_max = 11;

  priority_task_scheduler_with_delays u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic pts_out_t pick_next_task(pts_in_t b);
    pts_out_t              r;
    logic [DELAY_BITS-1:0] d;
    int                    s;
    r = '0;
    r.none_ready = 1'b1;
    if (b.mode == MODE_TICK) begin
      tick_cnt = tick_cnt + 1'b1;
      for (s = 0; s < TASK_SLOTS; s++) begin
        if (task_here[s] && task_waiting[s]) begin
          wait_left[s] = wait_left[s] - 1'b1;
          if (wait_left[s] == '0) task_waiting[s] = 1'b0;
        end
      end
    end else if (int'(b.task_prio) < TASK_SLOTS) begin
      case (b.mode)
        MODE_CREATE: begin
          task_here[b.task_prio] = 1'b1;
          task_waiting[b.task_prio] = 1'b0;
          wait_left[b.task_prio] = '0;
        end
        MODE_DELETE: begin
          task_here[b.task_prio] = 1'b0;
          task_waiting[b.task_prio] = 1'b0;
        end
        default: begin
          // delay of an absent slot is dropped
          if (task_here[b.task_prio]) begin
            d = DELAY_BITS'(b.delay_ticks);
            wait_left[b.task_prio] = d;
            task_waiting[b.task_prio] = (d != '0);
          end
        end
      endcase
    end
    for (s = 0; s < TASK_SLOTS; s++) begin
      if (task_here[s] && !task_waiting[s]) begin
        r.next_prio = PRIO_W'(s);
        r.none_ready = 1'b0;
        break;
      end
    end
    r.tick_now = tick_cnt;
    return r;
  endfunction

  task automatic add_row(pts_mode_e m, int prio, logic [DTICK_W-1:0] ticks, bit known,
                         int nxt, bit none, logic [TICK_W-1:0] tk);
    sched_row_t row;
    row.beat.mode = m;
    row.beat.task_prio = PRIO_W'(prio);
    row.beat.delay_ticks = ticks;
    row.known = known;
    row.want.next_prio = PRIO_W'(nxt);
    row.want.none_ready = none;
    row.want.tick_now = tk;
    dir_rows.push_back(row);
  endtask

  // holds valid across back-to-back beats so it is never dropped and raised in one step
  task automatic issue_op(pts_in_t b, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic pts_in_t rand_op();
    pts_in_t b;
    int      roll;
    roll = $urandom_range(0, 99);
    if (roll < 42) b.mode = MODE_TICK;
    else if (roll < 62) b.mode = MODE_CREATE;
    else if (roll < 75) b.mode = MODE_DELETE;
    else b.mode = MODE_DELAY;
    // crowd the low slots so tasks collide and preempt each other
    b.task_prio = $urandom_range(0, 1) ? PRIO_W'($urandom_range(0, 7)) : PRIO_W'($urandom);
    b.delay_ticks = $urandom;
    if (b.mode == MODE_DELAY) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) b.delay_ticks = '0;
      else if (roll < 80) b.delay_ticks = DTICK_W'($urandom_range(1, 12));
    end
    return b;
  endfunction

  task automatic report(string what, pts_out_t want, pts_out_t got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("%0t %s: want next=%0d none=%0b tick=%0d, got next=%0d none=%0b tick=%0d",
               $time, what, want.next_prio, want.none_ready, want.tick_now,
               got.next_prio, got.none_ready, got.tick_now);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      if (next_task_q.size() == 0) begin
        report("result beat with nothing pending", '0, out_data_o);
      end else begin
        if (out_data_o.next_prio !== next_task_q[0].next_prio ||
            out_data_o.none_ready !== next_task_q[0].none_ready ||
            out_data_o.tick_now !== next_task_q[0].tick_now)
          report("result mismatch", next_task_q[0], out_data_o);
        void'(next_task_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side stalls
  initial begin
    int stall;
    forever begin
      stall = $urandom_range(0, take_stall_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    pts_in_t  b;
    pts_out_t p;
    int       k;

    add_row(MODE_TICK,    0,  32'h0,         1,  0, 1, 1);
    add_row(MODE_CREATE,  31, 32'h0,         1, 31, 0, 1);
    add_row(MODE_CREATE,  0,  32'h0,         1,  0, 0, 1);
    add_row(MODE_DELAY,   0,  32'h0,         1,  0, 0, 1);  // zero delay keeps it ready
    add_row(MODE_DELAY,   0,  32'd2,         1, 31, 0, 1);
    add_row(MODE_DELETE,  5,  32'h0,         1, 31, 0, 1);  // delete of absent slot
    add_row(MODE_DELAY,   7,  32'd3,         1, 31, 0, 1);  // delay of absent slot
    add_row(MODE_TICK,    0,  32'h0,         1, 31, 0, 2);
    add_row(MODE_TICK,    0,  32'h0,         1,  0, 0, 3);  // slot 0 wakes
    add_row(MODE_DELAY,   0,  32'hFFFF_FFFF, 1, 31, 0, 3);
    add_row(MODE_CREATE,  0,  32'h0,         1,  0, 0, 3);  // recreate restarts it
    add_row(MODE_DELAY,   31, 32'd1,         1,  0, 0, 3);
    add_row(MODE_DELETE,  0,  32'h0,         1,  0, 1, 3);
    add_row(MODE_TICK,    0,  32'h0,         1, 31, 0, 4);
    add_row(MODE_DELAY,   31, 32'h8000_0000, 1,  0, 1, 4);
    add_row(MODE_CREATE,  16, 32'h0,         1, 16, 0, 4);
    add_row(MODE_DELETE,  16, 32'h0,         1,  0, 1, 4);
    add_row(MODE_CREATE,  31, 32'h0,         1, 31, 0, 4);
    add_row(MODE_CREATE,  3,  32'hFFFF_FFFF, 0,  0, 0, 0);
    add_row(MODE_TICK,    31, 32'h5555_5555, 0,  0, 0, 0);
    add_row(MODE_DELAY,   3,  32'd5,         0,  0, 0, 0);
    add_row(MODE_DELETE,  31, 32'hAAAA_AAAA, 0,  0, 0, 0);
    add_row(MODE_TICK,    0,  32'h0,         0,  0, 0, 0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < dir_rows.size(); k++) begin
      issue_op(dir_rows[k].beat, $urandom_range(0, send_gap_max));
      p = pick_next_task(dir_rows[k].beat);
      next_task_q.push_back(dir_rows[k].known ? dir_rows[k].want : p);
    end

    for (k = 0; k < RAND_OPS; k++) begin
      if (k % 100 == 0) begin
        send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 11;
        take_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 11;
      end
      if (k == RAND_OPS / 2) begin
        // let the scheduler drain completely before going on
        in_valid <= 1'b0;
        do @(posedge clk_i); while (next_task_q.size() != 0);
      end
      b = rand_op();
      issue_op(b, $urandom_range(0, send_gap_max));
      next_task_q.push_back(pick_next_task(b));
    end
    in_valid <= 1'b0;

    while (next_task_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_cnt == 0 && next_task_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
